// ----- src/rsi_pkg.sv -----
// Shared widths, field positions and payload types of the ray/segment intersection block.
package rsi_pkg;

    localparam int COORD_BITS = 16;

    // Differences of two coordinates need one more bit.
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = CROSS_W;
    localparam int QUO_W   = DIFF_W;
    localparam int NUM_W   = MAG_W + QUO_W;

    localparam int IN_FIELDS  = 8;
    localparam int IN_DATA_W  = ((IN_FIELDS * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_USER_W = 2;

    localparam int USER_HIT      = 0;
    localparam int USER_PARALLEL = 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord ray_src_x;
        t_coord ray_src_y;
        t_coord ray_dir_x;
        t_coord ray_dir_y;
        t_coord seg_start_x;
        t_coord seg_start_y;
        t_coord seg_end_x;
        t_coord seg_end_y;
    } t_item;

    // Classified test, waiting in the queue for the divide.
    typedef struct packed {
        logic              hit;
        logic              parallel;
        logic [MAG_W-1:0]  un_mag;
        logic [MAG_W-1:0]  det_mag;
        logic [QUO_W-1:0]  smag_x;
        logic [QUO_W-1:0]  smag_y;
        logic              neg_x;
        logic              neg_y;
        t_coord            start_x;
        t_coord            start_y;
    } t_job;

    typedef struct packed {
        logic valid;
        logic full;
    } t_qstat;

    typedef struct packed {
        logic   hit;
        logic   parallel;
        t_coord cross_x;
        t_coord cross_y;
    } t_result;

endpackage

// ----- src/rsi_front.sv -----
// Front end: differences, cross products, sign tests and hit classification.
module rsi_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rsi_pkg::t_item i_item,
    input  rsi_pkg::t_qstat i_qstat,
    output logic           o_push,
    output rsi_pkg::t_job  o_job
);
    import rsi_pkg::*;

    function automatic logic signed [DIFF_W-1:0] sext(input t_coord a);
        sext = {a[COORD_BITS-1], a};
    endfunction

    function automatic logic signed [CROSS_W-1:0] pext(input logic signed [PROD_W-1:0] a);
        pext = {a[PROD_W-1], a};
    endfunction

    logic en;

    // stage 1: differences
    logic                     r_v1;
    logic signed [DIFF_W-1:0] r_sx, r_sy, r_bx, r_by, r_dx, r_dy;
    t_coord                   r1_ssx, r1_ssy;

    // stage 2: products
    logic                     r_v2;
    logic signed [PROD_W-1:0] r_sxdy, r_dxsy, r_sxby, r_bxsy, r_dxby, r_dybx;
    logic [QUO_W-1:0]         r2_smag_x, r2_smag_y;
    logic                     r2_sx_neg, r2_sy_neg;
    t_coord                   r2_ssx, r2_ssy;

    // stage 3: determinant and numerators
    logic                      r_v3;
    logic signed [CROSS_W-1:0] r_det, r_tn, r_un;
    logic [QUO_W-1:0]          r3_smag_x, r3_smag_y;
    logic                      r3_sx_neg, r3_sy_neg;
    t_coord                    r3_ssx, r3_ssy;

    // stage 4: magnitudes and sign tests
    logic             r_v4;
    logic             r4_parallel, r4_t_pos, r4_u_nonneg;
    logic [MAG_W-1:0] r4_un_mag, r4_det_mag;
    logic [QUO_W-1:0] r4_smag_x, r4_smag_y;
    logic             r4_neg_x, r4_neg_y;
    t_coord           r4_ssx, r4_ssy;

    logic signed [DIFF_W-1:0] n_sx, n_sy;
    logic                     n_det_neg, n_un_neg, n_tn_neg;

    // Stall the whole front together when the queue cannot take its last stage.
    assign en      = !r_v4 || !i_qstat.full;
    assign o_ready = en;
    assign o_push  = r_v4 && !i_qstat.full;

    assign n_sx      = sext(i_item.seg_end_x) - sext(i_item.seg_start_x);
    assign n_sy      = sext(i_item.seg_end_y) - sext(i_item.seg_start_y);
    assign n_det_neg = r_det[CROSS_W-1];
    assign n_un_neg  = r_un[CROSS_W-1];
    assign n_tn_neg  = r_tn[CROSS_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx   <= n_sx;
            r_sy   <= n_sy;
            r_bx   <= sext(i_item.seg_start_x) - sext(i_item.ray_src_x);
            r_by   <= sext(i_item.seg_start_y) - sext(i_item.ray_src_y);
            r_dx   <= sext(i_item.ray_dir_x);
            r_dy   <= sext(i_item.ray_dir_y);
            r1_ssx <= i_item.seg_start_x;
            r1_ssy <= i_item.seg_start_y;

            r_sxdy    <= r_sx * r_dy;
            r_dxsy    <= r_dx * r_sy;
            r_sxby    <= r_sx * r_by;
            r_bxsy    <= r_bx * r_sy;
            r_dxby    <= r_dx * r_by;
            r_dybx    <= r_dy * r_bx;
            r2_sx_neg <= r_sx[DIFF_W-1];
            r2_sy_neg <= r_sy[DIFF_W-1];
            r2_smag_x <= r_sx[DIFF_W-1] ? QUO_W'(-r_sx) : QUO_W'(r_sx);
            r2_smag_y <= r_sy[DIFF_W-1] ? QUO_W'(-r_sy) : QUO_W'(r_sy);
            r2_ssx    <= r1_ssx;
            r2_ssy    <= r1_ssy;

            r_det     <= pext(r_sxdy) - pext(r_dxsy);
            r_tn      <= pext(r_sxby) - pext(r_bxsy);
            r_un      <= pext(r_dxby) - pext(r_dybx);
            r3_smag_x <= r2_smag_x;
            r3_smag_y <= r2_smag_y;
            r3_sx_neg <= r2_sx_neg;
            r3_sy_neg <= r2_sy_neg;
            r3_ssx    <= r2_ssx;
            r3_ssy    <= r2_ssy;

            r4_parallel <= (r_det == '0);
            r4_t_pos    <= (r_tn != '0) && (n_tn_neg == n_det_neg);
            r4_u_nonneg <= (r_un == '0) || (n_un_neg == n_det_neg);
            r4_un_mag   <= n_un_neg ? MAG_W'(-r_un) : MAG_W'(r_un);
            r4_det_mag  <= n_det_neg ? MAG_W'(-r_det) : MAG_W'(r_det);
            r4_neg_x    <= n_un_neg ^ r3_sx_neg ^ n_det_neg;
            r4_neg_y    <= n_un_neg ^ r3_sy_neg ^ n_det_neg;
            r4_smag_x   <= r3_smag_x;
            r4_smag_y   <= r3_smag_y;
            r4_ssx      <= r3_ssx;
            r4_ssy      <= r3_ssy;
        end
    end

    // Segment parameter must not pass one: compare magnitudes.
    always_comb begin
        o_job.hit      = !r4_parallel && r4_t_pos && r4_u_nonneg && (r4_un_mag <= r4_det_mag);
        o_job.parallel = r4_parallel;
        o_job.un_mag   = r4_un_mag;
        o_job.det_mag  = r4_det_mag;
        o_job.smag_x   = r4_smag_x;
        o_job.smag_y   = r4_smag_y;
        o_job.neg_x    = r4_neg_x;
        o_job.neg_y    = r4_neg_y;
        o_job.start_x  = r4_ssx;
        o_job.start_y  = r4_ssy;
    end

endmodule

// ----- src/rsi_queue.sv -----
// Short first-in first-out queue of classified tests between front and back end.
module rsi_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rsi_pkg::t_job   i_job,
    input  logic            i_pop,
    output rsi_pkg::t_job   o_job,
    output rsi_pkg::t_qstat o_stat
);
    import rsi_pkg::*;

    function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
        next_ptr = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_stat.valid = (r_cnt != '0);
    assign o_stat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_job        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= next_ptr(r_wr);
            end
            if (i_pop) begin
                r_rd <= next_ptr(r_rd);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ----- src/rsi_back.sv -----
// Back end: scaled products, pipelined restoring divide, point assembly and output skid.
module rsi_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rsi_pkg::t_qstat  i_qstat,
    output logic             o_pop,
    input  rsi_pkg::t_job    i_job,
    output logic             o_valid,
    input  logic             i_ready,
    output rsi_pkg::t_result o_result
);
    import rsi_pkg::*;

    typedef struct packed {
        logic             hit;
        logic             parallel;
        logic [MAG_W-1:0] det_mag;
        logic             neg_x;
        logic             neg_y;
        t_coord           start_x;
        t_coord           start_y;
    } t_tag;

    // Partial remainder and the numerator bits still to shift in; quotient bits
    // enter at the low end.
    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [QUO_W-1:0] sh;
    } t_dstep;

    function automatic t_dstep div_step(input t_dstep a, input logic [MAG_W-1:0] d);
        logic [MAG_W:0] trial;
        logic [MAG_W:0] diff;
        t_dstep         r;
        trial = {a.rem, a.sh[QUO_W-1]};
        diff  = trial - {1'b0, d};
        if (trial >= {1'b0, d}) begin
            r.rem = diff[MAG_W-1:0];
            r.sh  = {a.sh[QUO_W-2:0], 1'b1};
        end else begin
            r.rem = trial[MAG_W-1:0];
            r.sh  = {a.sh[QUO_W-2:0], 1'b0};
        end
        div_step = r;
    endfunction

    logic en;

    logic             r_mv;
    t_tag             r_mtag;
    logic [NUM_W-1:0] r_nx, r_ny;

    logic   r_dv   [QUO_W];
    t_tag   r_dtag [QUO_W];
    t_dstep r_qx   [QUO_W];
    t_dstep r_qy   [QUO_W];

    t_tag   s_tag_in [QUO_W];
    t_dstep s_x_in   [QUO_W];
    t_dstep s_y_in   [QUO_W];

    t_tag             s_last;
    logic [QUO_W-1:0] s_qx, s_qy;
    t_result          n_res;
    logic             s_in_v;

    logic    r_out_v, r_skid_v;
    t_result r_out, r_skid;

    // The divide pipeline moves whenever the skid slot is free.
    assign en    = !r_skid_v;
    assign o_pop = en && i_qstat.valid;

    always_comb begin
        s_tag_in[0] = r_mtag;
        s_x_in[0]   = '{rem: r_nx[NUM_W-1:QUO_W], sh: r_nx[QUO_W-1:0]};
        s_y_in[0]   = '{rem: r_ny[NUM_W-1:QUO_W], sh: r_ny[QUO_W-1:0]};
        for (int k = 1; k < QUO_W; k++) begin
            s_tag_in[k] = r_dtag[k-1];
            s_x_in[k]   = r_qx[k-1];
            s_y_in[k]   = r_qy[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
            for (int k = 0; k < QUO_W; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (en) begin
            r_mv    <= o_pop;
            r_dv[0] <= r_mv;
            for (int k = 1; k < QUO_W; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mtag.hit      <= i_job.hit;
            r_mtag.parallel <= i_job.parallel;
            r_mtag.det_mag  <= i_job.det_mag;
            r_mtag.neg_x    <= i_job.neg_x;
            r_mtag.neg_y    <= i_job.neg_y;
            r_mtag.start_x  <= i_job.start_x;
            r_mtag.start_y  <= i_job.start_y;
            r_nx            <= i_job.un_mag * i_job.smag_x;
            r_ny            <= i_job.un_mag * i_job.smag_y;
            for (int k = 0; k < QUO_W; k++) begin
                r_dtag[k] <= s_tag_in[k];
                r_qx[k]   <= div_step(s_x_in[k], s_tag_in[k].det_mag);
                r_qy[k]   <= div_step(s_y_in[k], s_tag_in[k].det_mag);
            end
        end
    end

    // Apply the sign and add the start point; a miss reads as zero.
    assign s_last = r_dtag[QUO_W-1];
    assign s_qx   = r_qx[QUO_W-1].sh;
    assign s_qy   = r_qy[QUO_W-1].sh;
    assign s_in_v = r_dv[QUO_W-1];

    always_comb begin
        n_res.hit      = s_last.hit;
        n_res.parallel = s_last.parallel;
        n_res.cross_x  = '0;
        n_res.cross_y  = '0;
        if (s_last.hit) begin
            n_res.cross_x = s_last.neg_x ? s_last.start_x - s_qx[COORD_BITS-1:0]
                                         : s_last.start_x + s_qx[COORD_BITS-1:0];
            n_res.cross_y = s_last.neg_y ? s_last.start_y - s_qy[COORD_BITS-1:0]
                                         : s_last.start_y + s_qy[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (i_ready || !r_out_v) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= s_in_v;
            end
        end else if (s_in_v && !r_skid_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ready || !r_out_v) begin
            r_out <= r_skid_v ? r_skid : n_res;
        end else if (!r_skid_v) begin
            r_skid <= n_res;
        end
    end

    assign o_valid  = r_out_v;
    assign o_result = r_out;

endmodule

// ----- src/ray_segment_intersect_top.sv -----
// Top level of the 2D ray against line segment intersection block.
//
// Channel   Dir  Signals                         Carries
// s_axis    in   tvalid tready tdata[127:0]      ray and segment, signed Q7.8 coordinates
// m_axis    out  tvalid tready tdata[31:0] tuser hit/parallel flags and intersection point
//
// Throughput is one transfer per cycle on each side when nothing stalls. A result passes
// through the four front stages (differences, products, cross terms, sign tests), the
// queue, one multiply stage and the 17-stage restoring divider, one quotient bit per
// stage, then the output register.
// Reset is synchronous and active low; it empties every stage, the queue and the skid.
// A stall on m_axis fills the skid, freezes the back end and lets the queue absorb up to
// four tests before s_axis_tready drops.
module ray_segment_intersect_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // ray_src_x, ray_src_y, ray_dir_x, ray_dir_y, seg_start_x, seg_start_y,
    // seg_end_x, seg_end_y (lowest bits first)
    input  logic [rsi_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // cross_x, cross_y (lowest bits first)
    output logic [rsi_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // hit, parallel (lowest bit first)
    output logic [rsi_pkg::OUT_USER_W-1:0]    m_axis_tuser
);
    import rsi_pkg::*;

    t_item   s_item;
    t_job    s_push_job, s_pop_job;
    t_qstat  s_qstat;
    t_result s_res;
    logic    s_push, s_pop;

    // Unpack the input transfer; the first field sits in the lowest bits.
    always_comb begin
        s_item.ray_src_x   = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
        s_item.ray_src_y   = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
        s_item.ray_dir_x   = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
        s_item.ray_dir_y   = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
        s_item.seg_start_x = s_axis_tdata[4*COORD_BITS +: COORD_BITS];
        s_item.seg_start_y = s_axis_tdata[5*COORD_BITS +: COORD_BITS];
        s_item.seg_end_x   = s_axis_tdata[6*COORD_BITS +: COORD_BITS];
        s_item.seg_end_y   = s_axis_tdata[7*COORD_BITS +: COORD_BITS];
    end

    // Classify: cross products and the exact sign tests for a hit.
    rsi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (s_item),
        .i_qstat (s_qstat),
        .o_push  (s_push),
        .o_job   (s_push_job)
    );

    // Decouple the two halves so each may stall on its own.
    rsi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_job   (s_push_job),
        .i_pop   (s_pop),
        .o_job   (s_pop_job),
        .o_stat  (s_qstat)
    );

    // Divide, place the point on the segment and hold the result for transfer.
    rsi_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qstat  (s_qstat),
        .o_pop    (s_pop),
        .i_job    (s_pop_job),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (s_res)
    );

    // Pack the result; any bits above the two coordinates stay zero.
    always_comb begin
        m_axis_tdata                               = '0;
        m_axis_tdata[0*COORD_BITS +: COORD_BITS]   = s_res.cross_x;
        m_axis_tdata[1*COORD_BITS +: COORD_BITS]   = s_res.cross_y;
        m_axis_tuser                               = '0;
        m_axis_tuser[USER_HIT]                     = s_res.hit;
        m_axis_tuser[USER_PARALLEL]                = s_res.parallel;
    end

`ifndef NO_ASSERTIONS
    // A miss or a parallel pair carries a zero point.
    a_miss_zero_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[USER_HIT]) |-> (m_axis_tdata == '0))
        else $error("miss delivered with a nonzero point");

    // A zero determinant can never be reported as a hit.
    a_hit_not_parallel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[USER_HIT] && m_axis_tuser[USER_PARALLEL]))
        else $error("hit and parallel flags both set");

    // The front may only hold off the source while the queue is full.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> s_qstat.full)
        else $error("input stalled with room in the queue");
`endif

endmodule

// ----- tb/sv/ray_segment_intersect_checker.sv -----
// Checker that predicts and compares every result of the ray/segment intersection block.
`timescale 1ns / 100ps

module ray_segment_intersect_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    // ray_src_x, ray_src_y, ray_dir_x, ray_dir_y, seg_start_x, seg_start_y,
    // seg_end_x, seg_end_y (lowest bits first)
    input  logic [rsi_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // cross_x, cross_y (lowest bits first)
    input  logic [rsi_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // hit, parallel (lowest bit first)
    input  logic [rsi_pkg::OUT_USER_W-1:0] m_axis_tuser,
    output int                             o_pending,
    output int                             o_fail_count
);
    import rsi_pkg::*;

    localparam int CB = COORD_BITS;

    t_result awaited_crossings[$];
    t_result want;
    t_result got;
    t_item   tested;
    int      mismatch_count;

    // start + (un*s)/det, quotient truncated toward zero
    function automatic t_coord point_along(longint start, longint s, longint un, longint det);
        longint unsigned un_mag;
        longint unsigned s_mag;
        longint unsigned det_mag;
        longint unsigned quot;
        longint          pos;
        un_mag  = (un < 0) ? longint'(-un) : longint'(un);
        s_mag   = (s < 0) ? longint'(-s) : longint'(s);
        det_mag = (det < 0) ? longint'(-det) : longint'(det);
        quot    = (un_mag * s_mag) / det_mag;
        if ((un < 0) ^ (s < 0) ^ (det < 0))
            pos = start - longint'(quot);
        else
            pos = start + longint'(quot);
        return pos[CB-1:0];
    endfunction

    function automatic t_result intersect_ray_segment(t_item it);
        longint  sx, sy, bx, by, det, tn, un;
        bit      t_pos, u_nonneg, u_le_one;
        t_result r;
        sx  = longint'(it.seg_end_x) - longint'(it.seg_start_x);
        sy  = longint'(it.seg_end_y) - longint'(it.seg_start_y);
        bx  = longint'(it.seg_start_x) - longint'(it.ray_src_x);
        by  = longint'(it.seg_start_y) - longint'(it.ray_src_y);
        det = sx * longint'(it.ray_dir_y) - longint'(it.ray_dir_x) * sy;
        tn  = sx * by - bx * sy;
        un  = longint'(it.ray_dir_x) * by - longint'(it.ray_dir_y) * bx;
        r   = '0;
        if (det == 0) begin
            // parallel lines, zero direction or zero-length segment
            r.parallel = 1'b1;
        end else begin
            t_pos    = (tn != 0) && ((tn < 0) == (det < 0));
            u_nonneg = (un == 0) || ((un < 0) == (det < 0));
            u_le_one = ((un < 0) ? -un : un) <= ((det < 0) ? -det : det);
            if (t_pos && u_nonneg && u_le_one) begin
                r.hit     = 1'b1;
                r.cross_x = point_along(longint'(it.seg_start_x), sx, un, det);
                r.cross_y = point_along(longint'(it.seg_start_y), sy, un, det);
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            awaited_crossings.delete();
            mismatch_count = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.hit      = m_axis_tuser[USER_HIT];
                got.parallel = m_axis_tuser[USER_PARALLEL];
                got.cross_x  = m_axis_tdata[0 +: CB];
                got.cross_y  = m_axis_tdata[CB +: CB];
                if (awaited_crossings.size() == 0) begin
                    $error("result transfer with no test outstanding");
                    mismatch_count++;
                end else begin
                    want = awaited_crossings.pop_front();
                    if (got.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, got.hit);
                        mismatch_count++;
                    end
                    if (got.parallel !== want.parallel) begin
                        $error("parallel: expected %0d, got %0d", want.parallel, got.parallel);
                        mismatch_count++;
                    end
                    if (got.cross_x !== want.cross_x) begin
                        $error("cross_x: expected %0d, got %0d", want.cross_x, got.cross_x);
                        mismatch_count++;
                    end
                    if (got.cross_y !== want.cross_y) begin
                        $error("cross_y: expected %0d, got %0d", want.cross_y, got.cross_y);
                        mismatch_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                tested.ray_src_x   = s_axis_tdata[0*CB +: CB];
                tested.ray_src_y   = s_axis_tdata[1*CB +: CB];
                tested.ray_dir_x   = s_axis_tdata[2*CB +: CB];
                tested.ray_dir_y   = s_axis_tdata[3*CB +: CB];
                tested.seg_start_x = s_axis_tdata[4*CB +: CB];
                tested.seg_start_y = s_axis_tdata[5*CB +: CB];
                tested.seg_end_x   = s_axis_tdata[6*CB +: CB];
                tested.seg_end_y   = s_axis_tdata[7*CB +: CB];
                awaited_crossings.push_back(intersect_ray_segment(tested));
            end
        end
        o_pending    <= awaited_crossings.size();
        o_fail_count <= mismatch_count;
    end

endmodule

// ----- tb/sv/ray_segment_intersect_top_test.sv -----
// Stimulus, flow control and verdict for the ray/segment intersection block.
`timescale 1ns / 100ps

module ray_segment_intersect_top_test;
    import rsi_pkg::*;

    localparam int CB          = COORD_BITS;
    localparam int PHASE_ITEMS = 325;   // random tests in each of the four phases
    localparam int DRAIN_WAIT  = 40;    // comfortably above the latency from input to result
    localparam int STALL_LIMIT = 2000;  // cycles without any transfer before giving up

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // ray_src_x, ray_src_y, ray_dir_x, ray_dir_y, seg_start_x, seg_start_y,
    // seg_end_x, seg_end_y (lowest bits first)
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // cross_x, cross_y (lowest bits first)
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // hit, parallel (lowest bit first)
    logic [OUT_USER_W-1:0] m_axis_tuser;

    int pending;
    int fail_count;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    ray_segment_intersect_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    ray_segment_intersect_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Drop tready at random on the result side; the rate follows the current phase.
    initial m_axis_tready = 1'b0;
    always @(negedge i_clk) begin
        m_axis_tready <= (int'($urandom_range(99)) >= recv_stall_pct);
    end

    // Count cycles with no transfer on either side and abort if the block locks up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("** ray_segment_intersect_top: FAILED **");
                $finish;
            end
        end
    end

    function automatic t_item item_of(int rx, int ry, int dx, int dy,
                                      int ax, int ay, int bx, int by);
        t_item it;
        it.ray_src_x   = rx[CB-1:0];
        it.ray_src_y   = ry[CB-1:0];
        it.ray_dir_x   = dx[CB-1:0];
        it.ray_dir_y   = dy[CB-1:0];
        it.seg_start_x = ax[CB-1:0];
        it.seg_start_y = ay[CB-1:0];
        it.seg_end_x   = bx[CB-1:0];
        it.seg_end_y   = by[CB-1:0];
        return it;
    endfunction

    // Uniform in -span..span.
    function automatic int spread(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // Build one random test. Most are shaped so the interesting paths get exercised:
    // rays aimed at a point on the segment (including both end points), parallel and
    // degenerate geometry, origins lying on the segment, and tiny coordinates where
    // exact ties are common. The rest use the full coordinate range.
    function automatic t_item random_test();
        int pick, rx, ry, ax, ay, sx, sy, px, py, k, m;
        pick = $urandom_range(99);
        if (pick < 35) begin
            return item_of($urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 65) begin
            // aim at start + k/8 of the way along; k of 0 and 8 hit the ends exactly
            rx = spread(8191);
            ry = spread(8191);
            ax = spread(8191);
            ay = spread(8191);
            sx = spread(8191) - ax / 2;
            sy = spread(8191) - ay / 2;
            k  = $urandom_range(8);
            px = ax + (sx * k) / 8;
            py = ay + (sy * k) / 8;
            m  = $urandom_range(2, 1);
            return item_of(rx, ry, (px - rx) * m, (py - ry) * m, ax, ay, ax + sx, ay + sy);
        end else if (pick < 77) begin
            // direction a multiple of the segment, or a zero-length segment
            ax = spread(16383);
            ay = spread(16383);
            sx = spread(4095);
            sy = spread(4095);
            m  = int'($urandom_range(6)) - 3;
            if ($urandom_range(3) == 0)
                return item_of(spread(32767), spread(32767), spread(32767), spread(32767),
                               ax, ay, ax, ay);
            return item_of(spread(32767), spread(32767), sx * m, sy * m,
                           ax, ay, ax + sx, ay + sy);
        end else if (pick < 89) begin
            // origin on the segment: a ray that starts there never counts as a hit
            ax = spread(16383);
            ay = spread(16383);
            sx = 8 * spread(2047);
            sy = 8 * spread(2047);
            k  = $urandom_range(8);
            return item_of(ax + (sx / 8) * k, ay + (sy / 8) * k, spread(32767), spread(32767),
                           ax, ay, ax + sx, ay + sy);
        end
        return item_of(spread(8), spread(8), spread(8), spread(8),
                       spread(8), spread(8), spread(8), spread(8));
    endfunction

    // Present one test and hold it until it is transferred; idle beforehand as the
    // phase asks. Called at a falling edge and returns at a falling edge.
    task automatic put_test(input t_item it);
        while (int'($urandom_range(99)) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.seg_end_y, it.seg_end_x, it.seg_start_y, it.seg_start_x,
                          it.ray_dir_y, it.ray_dir_x, it.ray_src_y, it.ray_src_x};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed tests, Q7.8 (256 is one unit), no idling on either side.
        put_test(item_of(0, 0, 0, 0, 0, 0, 0, 0));
        put_test(item_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        put_test(item_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
        put_test(item_of(16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                         16'haaaa, 16'h5555, 16'h5555, 16'haaaa));
        put_test(item_of(0, 0, 256, 0, 512, -256, 512, 256));      // plain hit
        put_test(item_of(0, 0, 256, 0, 512, 0, 512, 256));         // through the start point
        put_test(item_of(0, 0, 256, 0, 512, -256, 512, 0));        // through the end point
        put_test(item_of(0, 0, -256, 0, 512, -256, 512, 256));     // segment behind the ray
        put_test(item_of(512, 0, 256, 0, 512, -256, 512, 256));    // origin on the segment
        put_test(item_of(0, 0, 256, 0, 512, -256, 512, -1));      // just past the end
        put_test(item_of(0, 0, 256, 0, 512, 1, 512, 256));         // just before the start
        put_test(item_of(0, 0, 256, 0, 512, 0, 1024, 0));          // collinear
        put_test(item_of(0, 0, 256, 256, 0, 512, 512, 1024));      // parallel, offset
        put_test(item_of(0, 0, 0, 0, 512, -256, 512, 256));        // zero direction
        put_test(item_of(0, 0, 256, 0, 512, 0, 512, 0));           // zero-length segment
        put_test(item_of(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767));
        put_test(item_of(32767, 0, -32768, 0, 0, -32768, 0, 32767));
        put_test(item_of(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767));
        put_test(item_of(0, 0, 3, 1, 1, -5, 1, 7));                // inexact quotient
        put_test(item_of(0, 0, -3, -1, -1, 5, -1, -7));            // same, negative side
        put_test(item_of(0, 0, 256, 0, 512, 256, 512, 768));       // line misses, u < 0

        // Random phases: free flow, idle sender, stalling receiver, then both.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            repeat (PHASE_ITEMS) put_test(random_test());
        end
        s_axis_tvalid <= 1'b0;

        // Drain: wait until every expected result has arrived, then allow the
        // pipeline time to show any stray output.
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("** ray_segment_intersect_top: PASSED **");
        end else begin
            $display("** ray_segment_intersect_top: FAILED **");
        end
        $finish;
    end

endmodule
